/* src/facb_pkg.sv */
// Shared types and codes for the face adjacency CSR builder.
// Used by the controller, the datapath and the top level.
package facb_pkg;

  localparam int DEF_MAX_CELLS = 1024;
  localparam int DEF_MAX_FACES = 2048;
  localparam int NUM_CELLS_RST = 1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_SEG   = 2'd2;
  localparam logic [1:0] CMD_ENTRY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef enum logic [2:0] {
    RSP_NONE,
    RSP_LOAD,
    RSP_BUILD,
    RSP_SEG,
    RSP_ENT
  } rsp_t;

  typedef struct packed {
    logic acc;
    logic idx_clr;
    logic idx_inc;
    logic run_clr;
    logic cnt_clr;
    logic face_rd;
    logic face_lat;
    logic sel_n;
    logic cnt_rd;
    logic cnt_inc;
    logic scat;
    logic pre_rd;
    logic pre_wr;
    logic build_done;
    logic load_exe;
    logic seg_rd;
    logic ent_rd;
    rsp_t rsp;
  } ctl_t;

  typedef struct packed {
    logic face_end;
    logic cell_end;
    logic skip;
  } sts_t;

endpackage

/* src/face_adjacency_csr_builder.sv */
// Top level of the face adjacency CSR builder: controller plus datapath.
// Depends on facb_pkg, facb_controller and facb_datapath.
//
// A command beat is taken when start is high and busy is low; its one result
// appears on out_* with out_valid for a single cycle and cannot be held off.
// A build clears the counts, counts both cells of every kept face in a face
// pass, forms the prefix sum into the start memory, clears the counts again
// and scatters every kept face into the stencil in a second face pass; faces
// with an out-of-range cell are skipped, and the count memory is single-port.
module face_adjacency_csr_builder #(
  parameter int MAX_CELLS = facb_pkg::DEF_MAX_CELLS,
  parameter int MAX_FACES = facb_pkg::DEF_MAX_FACES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_owner_cell,
  input  logic [9:0]  in_neighbor_cell,
  input  logic [9:0]  in_query_cell,
  input  logic [11:0] in_entry_pos,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [12:0] out_segment_start,
  output logic [12:0] out_segment_length,
  output logic [10:0] out_face_index
);
  import facb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  facb_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  facb_datapath #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_FACES (MAX_FACES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_owner_cell      (in_owner_cell),
    .in_neighbor_cell   (in_neighbor_cell),
    .in_query_cell      (in_query_cell),
    .in_entry_pos       (in_entry_pos),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_segment_start  (out_segment_start),
    .out_segment_length (out_segment_length),
    .out_face_index     (out_face_index)
  );

endmodule

/* src/facb_datapath.sv */
// Datapath: face, count, start and stencil memories, index and sum registers.
// Driven by facb_controller through facb_pkg::ctl_t; depends on facb_pkg.
module facb_datapath #(
  parameter int MAX_CELLS = facb_pkg::DEF_MAX_CELLS,
  parameter int MAX_FACES = facb_pkg::DEF_MAX_FACES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  facb_pkg::ctl_t    ctl,
  output facb_pkg::sts_t    sts,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata,
  input  logic [9:0]        in_owner_cell,
  input  logic [9:0]        in_neighbor_cell,
  input  logic [9:0]        in_query_cell,
  input  logic [11:0]       in_entry_pos,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [12:0]       out_segment_start,
  output logic [12:0]       out_segment_length,
  output logic [10:0]       out_face_index
);
  import facb_pkg::*;

  localparam int SD     = 2 * MAX_FACES;
  localparam int CAW    = $clog2(MAX_CELLS);
  localparam int NCW    = $clog2(MAX_CELLS + 1);
  localparam int FAW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FCW    = $clog2(MAX_FACES + 1);
  localparam int SAW    = $clog2(SD);
  localparam int EW     = $clog2(SD + 1);
  localparam int IMAX   = (MAX_CELLS > MAX_FACES) ? MAX_CELLS : MAX_FACES;
  localparam int IW     = $clog2(IMAX + 1);
  localparam int NC_RST = (NUM_CELLS_RST > MAX_CELLS) ? MAX_CELLS : NUM_CELLS_RST;

  logic [NCW-1:0] num_cells_r;
  logic [FCW-1:0] faces_r;
  logic           ready_r;
  logic [EW-1:0]  total_r;
  logic [IW-1:0]  idx_r;
  logic [EW-1:0]  run_r;

  logic [9:0]  ld_own_r, ld_nbr_r, q_cell_r;
  logic [11:0] pos_r;

  logic [CAW-1:0] own_mem [MAX_FACES];
  logic [CAW-1:0] nbr_mem [MAX_FACES];
  logic [CAW-1:0] own_rd_r, nbr_rd_r, own_lat_r, nbr_lat_r;

  logic [EW-1:0] cnt_mem [MAX_CELLS];
  logic [EW-1:0] st_mem  [MAX_CELLS];
  logic [EW-1:0] cnt_rd_r, st_rd_r;

  logic [FAW-1:0] sten_mem [SD];
  logic [FAW-1:0] sten_rd_r;

  logic [CAW-1:0] cell_addr;
  logic [EW:0]    po;
  logic           full, load_ok;

  assign full    = 32'(faces_r) >= MAX_FACES;
  assign load_ok = !full && (32'(ld_own_r) < 32'(num_cells_r))
                         && (32'(ld_nbr_r) < 32'(num_cells_r));
  assign po      = {1'b0, st_rd_r} + {1'b0, cnt_rd_r};

  assign sts.face_end = 32'(idx_r) == 32'(faces_r);
  assign sts.cell_end = 32'(idx_r) == 32'(num_cells_r);
  assign sts.skip     = (32'(own_lat_r) >= 32'(num_cells_r))
                     || (32'(nbr_lat_r) >= 32'(num_cells_r));

  always_comb begin
    if (ctl.seg_rd) begin
      cell_addr = CAW'(q_cell_r);
    end else if (ctl.cnt_clr || ctl.pre_rd || ctl.pre_wr) begin
      cell_addr = CAW'(idx_r);
    end else if (ctl.sel_n) begin
      cell_addr = nbr_lat_r;
    end else begin
      cell_addr = own_lat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_exe && load_ok) begin
      own_mem[FAW'(faces_r)] <= CAW'(ld_own_r);
      nbr_mem[FAW'(faces_r)] <= CAW'(ld_nbr_r);
    end
    if (ctl.face_rd) begin
      own_rd_r <= own_mem[FAW'(idx_r)];
      nbr_rd_r <= nbr_mem[FAW'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_clr) begin
      cnt_mem[cell_addr] <= '0;
    end else if (ctl.cnt_inc) begin
      cnt_mem[cell_addr] <= cnt_rd_r + EW'(1);
    end
    if (ctl.cnt_rd || ctl.pre_rd || ctl.seg_rd) begin
      cnt_rd_r <= cnt_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre_wr) begin
      st_mem[cell_addr] <= run_r;
    end
    if (ctl.cnt_rd || ctl.seg_rd) begin
      st_rd_r <= st_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_inc && ctl.scat && (32'(po) < SD)) begin
      sten_mem[SAW'(po)] <= FAW'(idx_r);
    end
    if (ctl.ent_rd) begin
      sten_rd_r <= sten_mem[SAW'(pos_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      ld_own_r <= in_owner_cell;
      ld_nbr_r <= in_neighbor_cell;
      q_cell_r <= in_query_cell;
      pos_r    <= in_entry_pos;
    end
    if (ctl.face_lat) begin
      own_lat_r <= own_rd_r;
      nbr_lat_r <= nbr_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cells_r <= NCW'(NC_RST);
      faces_r     <= '0;
      ready_r     <= 1'b0;
      total_r     <= '0;
      idx_r       <= '0;
      run_r       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        ready_r <= 1'b0;
        if (cfg_wdata == 11'd0) begin
          num_cells_r <= NCW'(1);
        end else if (32'(cfg_wdata) > MAX_CELLS) begin
          num_cells_r <= NCW'(MAX_CELLS);
        end else begin
          num_cells_r <= NCW'(cfg_wdata);
        end
      end
      if (ctl.load_exe && load_ok) begin
        faces_r <= faces_r + FCW'(1);
        ready_r <= 1'b0;
      end
      if (ctl.build_done) begin
        ready_r <= 1'b1;
        total_r <= run_r;
      end
      if (ctl.idx_clr) begin
        idx_r <= '0;
      end else if (ctl.idx_inc) begin
        idx_r <= idx_r + IW'(1);
      end
      if (ctl.run_clr) begin
        run_r <= '0;
      end else if (ctl.pre_wr) begin
        run_r <= run_r + cnt_rd_r;
      end
      out_valid <= ctl.rsp != RSP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.rsp)
      RSP_LOAD: begin
        out_segment_start  <= '0;
        out_segment_length <= '0;
        if (full) begin
          out_status     <= ST_FULL;
          out_face_index <= '0;
        end else if (!load_ok) begin
          out_status     <= ST_RANGE;
          out_face_index <= '0;
        end else begin
          out_status     <= ST_OK;
          out_face_index <= 11'(faces_r);
        end
      end
      RSP_BUILD: begin
        out_status         <= ST_OK;
        out_segment_start  <= '0;
        out_segment_length <= '0;
        out_face_index     <= '0;
      end
      RSP_SEG: begin
        out_face_index     <= '0;
        out_segment_start  <= '0;
        out_segment_length <= '0;
        if (!ready_r) begin
          out_status <= ST_NOT_BUILT;
        end else if (32'(q_cell_r) >= 32'(num_cells_r)) begin
          out_status <= ST_RANGE;
        end else begin
          out_status         <= ST_OK;
          out_segment_start  <= 13'(st_rd_r);
          out_segment_length <= 13'(cnt_rd_r);
        end
      end
      RSP_ENT: begin
        out_segment_start  <= '0;
        out_segment_length <= '0;
        out_face_index     <= '0;
        if (!ready_r) begin
          out_status <= ST_NOT_BUILT;
        end else if ((32'(pos_r) >= 32'(total_r)) || (32'(pos_r) >= SD)) begin
          out_status <= ST_RANGE;
        end else begin
          out_status     <= ST_OK;
          out_face_index <= 11'(sten_rd_r);
        end
      end
      default: begin
        out_status <= out_status;
      end
    endcase
  end

endmodule

/* src/facb_controller.sv */
// Controller: command dispatch and the build sequencer (clear, count, prefix, scatter).
// Drives facb_datapath through facb_pkg::ctl_t; depends on facb_pkg.
module facb_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_cmd,
  input  facb_pkg::sts_t sts,
  output facb_pkg::ctl_t ctl,
  output logic           busy
);
  import facb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_QRD, S_QRSP, S_ERD, S_ERSP,
    S_CLR, S_FRD, S_FLAT, S_FCHK, S_FWO, S_FRN, S_FWN,
    S_PRE, S_PREWR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;

  always_comb begin
    ctl       = '0;
    ctl.rsp   = RSP_NONE;
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    ctl.scat  = pass2_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.acc = 1'b1;
          case (in_cmd)
            CMD_LOAD: state_nxt = S_LOAD;
            CMD_BUILD: begin
              ctl.idx_clr = 1'b1;
              pass2_nxt   = 1'b0;
              state_nxt   = S_CLR;
            end
            CMD_SEG: state_nxt = S_QRD;
            default: state_nxt = S_ERD;
          endcase
        end
      end
      S_LOAD: begin
        ctl.load_exe = 1'b1;
        ctl.rsp      = RSP_LOAD;
        state_nxt    = S_IDLE;
      end
      S_QRD: begin
        ctl.seg_rd = 1'b1;
        state_nxt  = S_QRSP;
      end
      S_QRSP: begin
        ctl.rsp   = RSP_SEG;
        state_nxt = S_IDLE;
      end
      S_ERD: begin
        ctl.ent_rd = 1'b1;
        state_nxt  = S_ERSP;
      end
      S_ERSP: begin
        ctl.rsp   = RSP_ENT;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (sts.cell_end) begin
          ctl.idx_clr = 1'b1;
          state_nxt   = S_FRD;
        end else begin
          ctl.cnt_clr = 1'b1;
          ctl.idx_inc = 1'b1;
        end
      end
      S_FRD: begin
        if (sts.face_end) begin
          ctl.idx_clr = 1'b1;
          ctl.run_clr = !pass2_r;
          state_nxt   = pass2_r ? S_FIN : S_PRE;
        end else begin
          ctl.face_rd = 1'b1;
          state_nxt   = S_FLAT;
        end
      end
      S_FLAT: begin
        ctl.face_lat = 1'b1;
        state_nxt    = S_FCHK;
      end
      S_FCHK: begin
        if (sts.skip) begin
          ctl.idx_inc = 1'b1;
          state_nxt   = S_FRD;
        end else begin
          ctl.cnt_rd = 1'b1;
          state_nxt  = S_FWO;
        end
      end
      S_FWO: begin
        ctl.cnt_inc = 1'b1;
        state_nxt   = S_FRN;
      end
      S_FRN: begin
        ctl.sel_n  = 1'b1;
        ctl.cnt_rd = 1'b1;
        state_nxt  = S_FWN;
      end
      S_FWN: begin
        ctl.sel_n   = 1'b1;
        ctl.cnt_inc = 1'b1;
        ctl.idx_inc = 1'b1;
        state_nxt   = S_FRD;
      end
      S_PRE: begin
        if (sts.cell_end) begin
          ctl.idx_clr = 1'b1;
          pass2_nxt   = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          ctl.pre_rd = 1'b1;
          state_nxt  = S_PREWR;
        end
      end
      S_PREWR: begin
        ctl.pre_wr  = 1'b1;
        ctl.idx_inc = 1'b1;
        state_nxt   = S_PRE;
      end
      S_FIN: begin
        ctl.build_done = 1'b1;
        ctl.rsp        = RSP_BUILD;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass2_r <= 1'b0;
      busy    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
      busy    <= state_nxt != S_IDLE;
    end
  end

endmodule

/* src/facb_checker.sv */
// Port-level checks for face_adjacency_csr_builder, attached by bind.
// Depends on facb_pkg for the status codes.
module facb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [12:0] out_segment_start,
  input logic [12:0] out_segment_length,
  input logic [10:0] out_face_index
);
  import facb_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_segment_start == 13'd0 && out_segment_length == 13'd0
       && out_face_index == 11'd0))
    else $error("error result carries nonzero fields");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

endmodule

bind face_adjacency_csr_builder facb_checker u_facb_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for face_adjacency_csr_builder: random and directed command beats
// checked against a scoreboard class with its own CSR build predictor.
// Depends on facb_pkg and the face_adjacency_csr_builder RTL.
module tb;
  import facb_pkg::*;

  localparam int CELLS = 1024;
  localparam int FACES = 2048;
  localparam int DEPTH = 2 * FACES;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    bit [1:0]  status;
    bit [12:0] seg_start;
    bit [12:0] seg_len;
    bit [10:0] face;
  } csr_result_t;

  class csr_scoreboard;
    int num_cells;
    bit [9:0] face_own[FACES];
    bit [9:0] face_nbr[FACES];
    int loaded;
    int cell_cnt[CELLS];
    int cell_start[CELLS];
    bit [10:0] stencil[DEPTH];
    bit ready;
    int total;
    int errors;
    csr_result_t pending[$];

    function new();
      num_cells = CELLS;
      loaded = 0;
      ready = 0;
      total = 0;
      errors = 0;
      foreach (cell_cnt[i]) cell_cnt[i] = 0;
    endfunction

    function void set_cells(bit [10:0] v);
      if (v == 0) num_cells = 1;
      else if (v > CELLS) num_cells = CELLS;
      else num_cells = v;
      ready = 0;
    endfunction

    function void build_csr();
      int run;
      int po;
      int pn;
      run = 0;
      foreach (cell_cnt[i]) cell_cnt[i] = 0;
      for (int f = 0; f < loaded; f++) begin
        if (face_own[f] >= num_cells || face_nbr[f] >= num_cells) continue;
        cell_cnt[face_own[f]]++;
        cell_cnt[face_nbr[f]]++;
      end
      for (int c = 0; c < num_cells; c++) begin
        cell_start[c] = run;
        run += cell_cnt[c];
      end
      total = run;
      foreach (cell_cnt[i]) cell_cnt[i] = 0;
      for (int f = 0; f < loaded; f++) begin
        if (face_own[f] >= num_cells || face_nbr[f] >= num_cells) continue;
        po = cell_start[face_own[f]] + cell_cnt[face_own[f]];
        cell_cnt[face_own[f]]++;
        pn = cell_start[face_nbr[f]] + cell_cnt[face_nbr[f]];
        cell_cnt[face_nbr[f]]++;
        if (po < DEPTH) stencil[po] = 11'(f);
        if (pn < DEPTH) stencil[pn] = 11'(f);
      end
      ready = 1;
    endfunction

    function void note(bit [1:0] cmd, bit [9:0] own, bit [9:0] nbr, bit [9:0] qc,
                       bit [11:0] pos);
      csr_result_t r;
      r = '{ST_OK, 0, 0, 0};
      if (cmd == CMD_LOAD) begin
        if (loaded >= FACES) r.status = ST_FULL;
        else if (own >= num_cells || nbr >= num_cells) r.status = ST_RANGE;
        else begin
          face_own[loaded] = own;
          face_nbr[loaded] = nbr;
          r.face = 11'(loaded);
          loaded++;
          ready = 0;
        end
      end else if (cmd == CMD_BUILD) begin
        build_csr();
      end else if (!ready) begin
        r.status = ST_NOT_BUILT;
      end else if (cmd == CMD_SEG) begin
        if (qc >= num_cells) r.status = ST_RANGE;
        else begin
          r.seg_start = 13'(cell_start[qc]);
          r.seg_len = 13'(cell_cnt[qc]);
        end
      end else begin
        if (pos >= total) r.status = ST_RANGE;
        else r.face = stencil[pos];
      end
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check(bit [1:0] st, bit [12:0] ss, bit [12:0] sl, bit [10:0] fi);
      csr_result_t r;
      if (pending.size() == 0) begin
        report("unexpected beat status", st, -1);
      end else begin
        r = pending.pop_front();
        if (st != r.status) report("status", st, r.status);
        if (ss != r.seg_start) report("segment_start", ss, r.seg_start);
        if (sl != r.seg_len) report("segment_length", sl, r.seg_len);
        if (fi != r.face) report("face_index", fi, r.face);
      end
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [10:0] cfg_wdata = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_cmd = 0;
  logic [9:0]  in_owner_cell = 0;
  logic [9:0]  in_neighbor_cell = 0;
  logic [9:0]  in_query_cell = 0;
  logic [11:0] in_entry_pos = 0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [12:0] out_segment_start;
  logic [12:0] out_segment_length;
  logic [10:0] out_face_index;

  csr_scoreboard sb = new();
  int cycles = 0;

  face_adjacency_csr_builder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_cmd(in_cmd), .in_owner_cell(in_owner_cell),
    .in_neighbor_cell(in_neighbor_cell), .in_query_cell(in_query_cell),
    .in_entry_pos(in_entry_pos), .out_valid(out_valid), .out_status(out_status),
    .out_segment_start(out_segment_start), .out_segment_length(out_segment_length),
    .out_face_index(out_face_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL face_adjacency_csr_builder");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check(out_status, out_segment_start, out_segment_length, out_face_index);
  end

  task send(bit [1:0] cmd, bit [9:0] own, bit [9:0] nbr, bit [9:0] qc, bit [11:0] pos);
    int gap;
    in_cmd <= cmd;
    in_owner_cell <= own;
    in_neighbor_cell <= nbr;
    in_query_cell <= qc;
    in_entry_pos <= pos;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note(cmd, own, nbr, qc, pos);
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_idle();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_cells(bit [10:0] v);
    wait_idle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_cells(v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function bit [9:0] pick_cell();
    if ($urandom_range(0, 99) < 85) return 10'($urandom_range(0, sb.num_cells - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  function bit [11:0] pick_pos();
    if (sb.total > 0 && $urandom_range(0, 99) < 80)
      return 12'($urandom_range(0, sb.total + 2));
    return 12'($urandom_range(0, 4095));
  endfunction

  task random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send(CMD_LOAD, pick_cell(), pick_cell(), 10'($urandom), 12'($urandom));
    else if (r < 46)
      send(CMD_BUILD, 10'($urandom), 10'($urandom), 10'($urandom), 12'($urandom));
    else if (r < 72)
      send(CMD_SEG, 10'($urandom), 10'($urandom), pick_cell(), 12'($urandom));
    else
      send(CMD_ENTRY, 10'($urandom), 10'($urandom), 10'($urandom), pick_pos());
  endtask

  bit [10:0] phase_cells[7] = '{11'd16, 11'd1024, 11'd3, 11'd200, 11'd1, 11'd2047, 11'd0};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: not built, extremes, self loop, shrunk mesh, stale, clamping
    send(CMD_SEG, 0, 0, 0, 0);
    send(CMD_ENTRY, 0, 0, 0, 0);
    send(CMD_LOAD, 0, 1023, 0, 0);
    send(CMD_LOAD, 1023, 0, 0, 0);
    send(CMD_LOAD, 5, 5, 0, 0);
    send(CMD_LOAD, 2, 1, 0, 0);
    send(CMD_BUILD, 0, 0, 0, 0);
    send(CMD_SEG, 0, 0, 0, 0);
    send(CMD_SEG, 0, 0, 1023, 0);
    send(CMD_SEG, 0, 0, 5, 0);
    send(CMD_ENTRY, 0, 0, 0, 0);
    send(CMD_ENTRY, 0, 0, 0, 7);
    send(CMD_ENTRY, 0, 0, 0, 8);
    send(CMD_ENTRY, 0, 0, 0, 4095);
    send(CMD_LOAD, 3, 3, 0, 0);
    send(CMD_SEG, 0, 0, 3, 0);
    write_cells(6);
    send(CMD_SEG, 0, 0, 0, 0);
    send(CMD_LOAD, 6, 0, 0, 0);
    send(CMD_BUILD, 0, 0, 0, 0);
    send(CMD_SEG, 0, 0, 1023, 0);
    send(CMD_SEG, 0, 0, 5, 0);
    send(CMD_ENTRY, 0, 0, 0, 3);
    write_cells(0);
    write_cells(2047);

    foreach (phase_cells[p]) begin
      if (p == 6) write_cells(11'($urandom_range(1, 1100)));
      else write_cells(phase_cells[p]);
      repeat (40) random_item();
    end

    // fill the face store, then overflow and build over the full set
    write_cells(1024);
    while (sb.loaded < FACES)
      send(CMD_LOAD, 10'($urandom), 10'($urandom), 10'($urandom), 12'($urandom));
    send(CMD_LOAD, 0, 0, 0, 0);
    send(CMD_LOAD, 1023, 1023, 0, 0);
    send(CMD_BUILD, 0, 0, 0, 0);
    repeat (40) random_item();
    write_cells(64);
    send(CMD_BUILD, 0, 0, 0, 0);
    repeat (40) random_item();

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS face_adjacency_csr_builder");
    end else begin
      $display("FAIL face_adjacency_csr_builder");
    end
    $finish;
  end
endmodule
